// ----- design/rv32im_instruction_encoder_defines.svh -----
// ---------------------------------------------------------------------------
// RV32IM instruction encoder: assertion macros
// Shared property wrappers, clocked on the rising edge and held off in reset.
// ---------------------------------------------------------------------------
`ifndef RV32IM_INSTRUCTION_ENCODER_DEFINES_SVH
`define RV32IM_INSTRUCTION_ENCODER_DEFINES_SVH

// Same-cycle implication: ante |-> cons.
`define RV32IE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error("rv32ie: property violated");

// Next-cycle implication: ante |=> cons.
`define RV32IE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rv32ie: property violated");

`endif

// ----- design/rv32ie_pkg.sv -----
// ---------------------------------------------------------------------------
// RV32IM instruction encoder package
// Mnemonic codes, major opcodes, fixed words and the transfer structs.
// ---------------------------------------------------------------------------
`default_nettype none

package rv32ie_pkg;

	typedef enum logic [5:0] {
		M_ADD, M_SUB, M_SLL, M_SLT, M_SLTU, M_XOR, M_SRL, M_SRA, M_OR, M_AND,
		M_MUL, M_MULH, M_MULHSU, M_MULHU, M_DIV, M_DIVU, M_REM, M_REMU,
		M_ADDI, M_SLLI, M_SLTI, M_SLTIU, M_XORI, M_SRLI, M_SRAI, M_ORI, M_ANDI,
		M_LB, M_LH, M_LW, M_LBU, M_LHU,
		M_SB, M_SH, M_SW,
		M_BEQ, M_BNE, M_BLT, M_BGE, M_BLTU, M_BGEU,
		M_LUI, M_AUIPC, M_JAL, M_JALR,
		M_ECALL, M_EBREAK, M_MRET,
		M_CSRRW, M_CSRRS, M_CSRRC,
		M_CSRRWI, M_CSRRSI, M_CSRRCI,
		M_LI, M_NOP, M_HALT
	} mode_t;

	// major opcodes
	localparam logic [6:0] OP_REG    = 7'h33;
	localparam logic [6:0] OP_IMM    = 7'h13;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_JAL    = 7'h6F;
	localparam logic [6:0] OP_LUI    = 7'h37;
	localparam logic [6:0] OP_AUIPC  = 7'h17;
	localparam logic [6:0] OP_SYSTEM = 7'h73;

	localparam logic [6:0] F7_ALT    = 7'h20;
	localparam logic [6:0] F7_MULDIV = 7'h01;
	localparam logic [11:0] SRAI_BIT = 12'h400;

	// fixed words
	localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
	localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;
	localparam logic [31:0] WORD_MRET   = 32'h3020_0073;
	localparam logic [31:0] WORD_NOP    = 32'h0000_0013;
	localparam logic [31:0] WORD_HALT   = 32'h0000_00FF;

	typedef struct packed {
		logic [5:0]  mode;
		logic [4:0]  dest_reg;
		logic [4:0]  src1_reg;
		logic [4:0]  src2_reg;
		logic signed [31:0] imm_value;
		logic [11:0] csr_addr;
	} cmd_t;

	typedef struct packed {
		logic [31:0] instr_word;
		logic        last_word;
		logic        bad_mode;
	} result_t;

endpackage

`default_nettype wire

// ----- design/rv32im_instruction_encoder.sv -----
// ---------------------------------------------------------------------------
// RV32IM instruction encoder
// Packs one parsed instruction into its RV32IM machine word or words.
// ---------------------------------------------------------------------------
// A command transfer happens on a rising edge with start high and busy low.
// The command lands in an input register; the encoded word is then
// registered onto result, where it sits for exactly one cycle with
// result_valid high. The receiver cannot stall: it must take every word
// in the cycle it is shown. One command per cycle is accepted while busy
// is low. The exception is li with an immediate outside the 12-bit signed
// range: it yields lui then addi back to back, and busy is high for a
// single cycle while the first word is assembled, so the input register
// holds the command for its second word and the next command waits.
// last_word marks the final word of each command; bad_mode flags an
// unused mnemonic code, which yields a single zero word.
// ---------------------------------------------------------------------------
`default_nettype none

`include "rv32im_instruction_encoder_defines.svh"

module rv32im_instruction_encoder (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire rv32ie_pkg::cmd_t  cmd,
	output logic                   busy,
	output logic                   result_valid,
	output rv32ie_pkg::result_t    result
);

	// input register
	rv32ie_pkg::cmd_t cmd_s1;
	logic             valid_s1;
	// second word of a wide li is due
	logic             phase_q;

	rv32ie_pkg::result_t result_q;
	logic                result_valid_q;

	logic [2:0]  f3;
	logic [19:0] li_upper;
	logic        li_wide;
	logic [31:0] word;
	logic        bad;
	logic        take;

	logic [4:0]  rd, rs1, rs2;
	logic [31:0] imm;

	assign rd  = cmd_s1.dest_reg;
	assign rs1 = cmd_s1.src1_reg;
	assign rs2 = cmd_s1.src2_reg;
	assign imm = cmd_s1.imm_value;

	// li: rounded upper part; fits in addi when it comes to zero
	assign li_upper = imm[31:12] + {19'd0, imm[11]};
	assign li_wide  = (cmd_s1.mode == rv32ie_pkg::M_LI) && (li_upper != 20'd0);

	// stall the input only while the first li word goes out
	assign busy = valid_s1 && li_wide && !phase_q;
	assign take = start && !busy;

	// funct3 per mnemonic
	always_comb begin
		unique case (cmd_s1.mode) inside
			rv32ie_pkg::M_SLL, rv32ie_pkg::M_MULH, rv32ie_pkg::M_SLLI,
			rv32ie_pkg::M_LH, rv32ie_pkg::M_SH, rv32ie_pkg::M_BNE,
			rv32ie_pkg::M_CSRRW: begin
				f3 = 3'd1;
			end
			rv32ie_pkg::M_SLT, rv32ie_pkg::M_MULHSU, rv32ie_pkg::M_SLTI,
			rv32ie_pkg::M_LW, rv32ie_pkg::M_SW, rv32ie_pkg::M_CSRRS: begin
				f3 = 3'd2;
			end
			rv32ie_pkg::M_SLTU, rv32ie_pkg::M_MULHU, rv32ie_pkg::M_SLTIU,
			rv32ie_pkg::M_CSRRC: begin
				f3 = 3'd3;
			end
			rv32ie_pkg::M_XOR, rv32ie_pkg::M_DIV, rv32ie_pkg::M_XORI,
			rv32ie_pkg::M_LBU, rv32ie_pkg::M_BLT: begin
				f3 = 3'd4;
			end
			rv32ie_pkg::M_SRL, rv32ie_pkg::M_SRA, rv32ie_pkg::M_DIVU,
			rv32ie_pkg::M_SRLI, rv32ie_pkg::M_SRAI, rv32ie_pkg::M_LHU,
			rv32ie_pkg::M_BGE, rv32ie_pkg::M_CSRRWI: begin
				f3 = 3'd5;
			end
			rv32ie_pkg::M_OR, rv32ie_pkg::M_REM, rv32ie_pkg::M_ORI,
			rv32ie_pkg::M_BLTU, rv32ie_pkg::M_CSRRSI: begin
				f3 = 3'd6;
			end
			rv32ie_pkg::M_AND, rv32ie_pkg::M_REMU, rv32ie_pkg::M_ANDI,
			rv32ie_pkg::M_BGEU, rv32ie_pkg::M_CSRRCI: begin
				f3 = 3'd7;
			end
			default: begin
				f3 = 3'd0;
			end
		endcase
	end

	// word assembly
	always_comb begin
		bad = 1'b0;
		unique case (cmd_s1.mode) inside
			[rv32ie_pkg::M_ADD:rv32ie_pkg::M_AND]: begin
				word = {((cmd_s1.mode == rv32ie_pkg::M_SUB) ||
					(cmd_s1.mode == rv32ie_pkg::M_SRA)) ? rv32ie_pkg::F7_ALT : 7'd0,
					rs2, rs1, f3, rd, rv32ie_pkg::OP_REG};
			end
			[rv32ie_pkg::M_MUL:rv32ie_pkg::M_REMU]: begin
				word = {rv32ie_pkg::F7_MULDIV, rs2, rs1, f3, rd, rv32ie_pkg::OP_REG};
			end
			rv32ie_pkg::M_SLLI: begin
				word = {7'd0, imm[4:0], rs1, f3, rd, rv32ie_pkg::OP_IMM};
			end
			rv32ie_pkg::M_SRAI: begin
				word = {imm[11:0] | rv32ie_pkg::SRAI_BIT, rs1, f3, rd, rv32ie_pkg::OP_IMM};
			end
			rv32ie_pkg::M_ADDI, rv32ie_pkg::M_SLTI, rv32ie_pkg::M_SLTIU,
			rv32ie_pkg::M_XORI, rv32ie_pkg::M_SRLI, rv32ie_pkg::M_ORI,
			rv32ie_pkg::M_ANDI: begin
				word = {imm[11:0], rs1, f3, rd, rv32ie_pkg::OP_IMM};
			end
			[rv32ie_pkg::M_LB:rv32ie_pkg::M_LHU]: begin
				word = {imm[11:0], rs1, f3, rd, rv32ie_pkg::OP_LOAD};
			end
			[rv32ie_pkg::M_SB:rv32ie_pkg::M_SW]: begin
				word = {imm[11:5], rs2, rs1, f3, imm[4:0], rv32ie_pkg::OP_STORE};
			end
			[rv32ie_pkg::M_BEQ:rv32ie_pkg::M_BGEU]: begin
				word = {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11],
					rv32ie_pkg::OP_BRANCH};
			end
			rv32ie_pkg::M_LUI: begin
				word = {imm[31:12], rd, rv32ie_pkg::OP_LUI};
			end
			rv32ie_pkg::M_AUIPC: begin
				word = {imm[31:12], rd, rv32ie_pkg::OP_AUIPC};
			end
			rv32ie_pkg::M_JAL: begin
				word = {imm[20], imm[10:1], imm[11], imm[19:12], rd, rv32ie_pkg::OP_JAL};
			end
			rv32ie_pkg::M_JALR: begin
				word = {imm[11:0], rs1, f3, rd, rv32ie_pkg::OP_JALR};
			end
			rv32ie_pkg::M_ECALL: begin
				word = rv32ie_pkg::WORD_ECALL;
			end
			rv32ie_pkg::M_EBREAK: begin
				word = rv32ie_pkg::WORD_EBREAK;
			end
			rv32ie_pkg::M_MRET: begin
				word = rv32ie_pkg::WORD_MRET;
			end
			[rv32ie_pkg::M_CSRRW:rv32ie_pkg::M_CSRRC]: begin
				word = {cmd_s1.csr_addr, rs1, f3, rd, rv32ie_pkg::OP_SYSTEM};
			end
			[rv32ie_pkg::M_CSRRWI:rv32ie_pkg::M_CSRRCI]: begin
				word = {cmd_s1.csr_addr, imm[4:0], f3, rd, rv32ie_pkg::OP_SYSTEM};
			end
			rv32ie_pkg::M_LI: begin
				if (!li_wide) begin
					word = {imm[11:0], 5'd0, 3'd0, rd, rv32ie_pkg::OP_IMM};
				end else if (!phase_q) begin
					word = {li_upper, rd, rv32ie_pkg::OP_LUI};
				end else begin
					// low part: imm - upper has the same low 12 bits as imm
					word = {imm[11:0], rd, 3'd0, rd, rv32ie_pkg::OP_IMM};
				end
			end
			rv32ie_pkg::M_NOP: begin
				word = rv32ie_pkg::WORD_NOP;
			end
			rv32ie_pkg::M_HALT: begin
				word = rv32ie_pkg::WORD_HALT;
			end
			default: begin
				word = 32'd0;
				bad  = 1'b1;
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			phase_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			valid_s1       <= take || busy;
			phase_q        <= busy;
			result_valid_q <= valid_s1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd;
		end
		if (valid_s1) begin
			result_q.instr_word <= word;
			result_q.last_word  <= !busy;
			result_q.bad_mode   <= bad;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

	// first li word is always followed by the closing word
	`RV32IE_ASSERT_NEXT(a_li_first, clk, arst_n, busy, result_valid && !result.last_word)
	`RV32IE_ASSERT_NEXT(a_li_second, clk, arst_n, result_valid && !result.last_word,
		result_valid && result.last_word && !result.bad_mode)
	`RV32IE_ASSERT_IMPL(a_bad_word, clk, arst_n, result_valid && result.bad_mode,
		(result.last_word && (result.instr_word == 32'd0)))
	`RV32IE_ASSERT_IMPL(a_latency, clk, arst_n, start && !busy, ##2 result_valid)

endmodule

`default_nettype wire

// ----- tb/tb_rv32im_instruction_encoder.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// RV32IM instruction encoder testbench
// Drives parsed instructions through the command handshake. A scoreboard
// class predicts the machine word or words for each command and compares
// every strobed result against the oldest prediction.
// ---------------------------------------------------------------------------

module tb_rv32im_instruction_encoder;

	localparam int RANDOM_ITEMS   = 1300;
	localparam int QUIET_FIRST    = 400;   // random items in this window never idle
	localparam int QUIET_LAST     = 700;
	localparam int TAIL_CYCLES    = 8;     // extra wait after drain for stray words
	localparam int WATCHDOG_LIMIT = 200;

	// -----------------------------------------------------------------------
	// Scoreboard: predicts encoded words, holds them in order, checks results
	// -----------------------------------------------------------------------
	class word_scoreboard;
		rv32ie_pkg::result_t expected_words[$];
		int                  errors = 0;

		function logic [31:0] r_word(logic [6:0] f7, logic [2:0] f3, rv32ie_pkg::cmd_t c);
			return {f7, c.src2_reg, c.src1_reg, f3, c.dest_reg, rv32ie_pkg::OP_REG};
		endfunction

		function logic [31:0] i_word(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
				logic [4:0] rd, logic [6:0] op);
			return {imm, rs1, f3, rd, op};
		endfunction

		function logic [31:0] s_word(logic [31:0] imm, logic [2:0] f3, rv32ie_pkg::cmd_t c);
			return {imm[11:5], c.src2_reg, c.src1_reg, f3, imm[4:0], rv32ie_pkg::OP_STORE};
		endfunction

		// bit 0 of the offset is dropped, as are bits above bit 12
		function logic [31:0] b_word(logic [31:0] imm, logic [2:0] f3, rv32ie_pkg::cmd_t c);
			return {imm[12], imm[10:5], c.src2_reg, c.src1_reg, f3, imm[4:1], imm[11],
				rv32ie_pkg::OP_BRANCH};
		endfunction

		function logic [31:0] j_word(logic [31:0] imm, logic [4:0] rd);
			return {imm[20], imm[10:1], imm[11], imm[19:12], rd, rv32ie_pkg::OP_JAL};
		endfunction

		function logic [31:0] csr_word(rv32ie_pkg::cmd_t c, logic [4:0] src, logic [2:0] f3);
			return {c.csr_addr, src, f3, c.dest_reg, rv32ie_pkg::OP_SYSTEM};
		endfunction

		function void push_word(logic [31:0] word, logic last, logic bad);
			rv32ie_pkg::result_t item;
			item.instr_word = word;
			item.last_word  = last;
			item.bad_mode   = bad;
			expected_words  = {expected_words, item};
		endfunction

		// Called on each command transfer
		function void note_command(rv32ie_pkg::cmd_t c);
			logic [31:0] imm;
			logic [31:0] shifted;
			logic [31:0] upper;
			logic [31:0] low;
			logic [31:0] word;
			logic        bad;
			logic [4:0]  rs1;
			logic [4:0]  rd;
			imm  = c.imm_value;
			rs1  = c.src1_reg;
			rd   = c.dest_reg;
			word = '0;
			bad  = 1'b0;
			case (c.mode)
				rv32ie_pkg::M_ADD:    word = r_word(7'h00, 3'd0, c);
				rv32ie_pkg::M_SUB:    word = r_word(rv32ie_pkg::F7_ALT, 3'd0, c);
				rv32ie_pkg::M_SLL:    word = r_word(7'h00, 3'd1, c);
				rv32ie_pkg::M_SLT:    word = r_word(7'h00, 3'd2, c);
				rv32ie_pkg::M_SLTU:   word = r_word(7'h00, 3'd3, c);
				rv32ie_pkg::M_XOR:    word = r_word(7'h00, 3'd4, c);
				rv32ie_pkg::M_SRL:    word = r_word(7'h00, 3'd5, c);
				rv32ie_pkg::M_SRA:    word = r_word(rv32ie_pkg::F7_ALT, 3'd5, c);
				rv32ie_pkg::M_OR:     word = r_word(7'h00, 3'd6, c);
				rv32ie_pkg::M_AND:    word = r_word(7'h00, 3'd7, c);
				rv32ie_pkg::M_MUL:    word = r_word(rv32ie_pkg::F7_MULDIV, 3'd0, c);
				rv32ie_pkg::M_MULH:   word = r_word(rv32ie_pkg::F7_MULDIV, 3'd1, c);
				rv32ie_pkg::M_MULHSU: word = r_word(rv32ie_pkg::F7_MULDIV, 3'd2, c);
				rv32ie_pkg::M_MULHU:  word = r_word(rv32ie_pkg::F7_MULDIV, 3'd3, c);
				rv32ie_pkg::M_DIV:    word = r_word(rv32ie_pkg::F7_MULDIV, 3'd4, c);
				rv32ie_pkg::M_DIVU:   word = r_word(rv32ie_pkg::F7_MULDIV, 3'd5, c);
				rv32ie_pkg::M_REM:    word = r_word(rv32ie_pkg::F7_MULDIV, 3'd6, c);
				rv32ie_pkg::M_REMU:   word = r_word(rv32ie_pkg::F7_MULDIV, 3'd7, c);
				rv32ie_pkg::M_ADDI:
					word = i_word(imm[11:0], rs1, 3'd0, rd, rv32ie_pkg::OP_IMM);
				rv32ie_pkg::M_SLLI:
					word = i_word({7'h00, imm[4:0]}, rs1, 3'd1, rd, rv32ie_pkg::OP_IMM);
				rv32ie_pkg::M_SLTI:
					word = i_word(imm[11:0], rs1, 3'd2, rd, rv32ie_pkg::OP_IMM);
				rv32ie_pkg::M_SLTIU:
					word = i_word(imm[11:0], rs1, 3'd3, rd, rv32ie_pkg::OP_IMM);
				rv32ie_pkg::M_XORI:
					word = i_word(imm[11:0], rs1, 3'd4, rd, rv32ie_pkg::OP_IMM);
				rv32ie_pkg::M_SRLI:
					word = i_word(imm[11:0], rs1, 3'd5, rd, rv32ie_pkg::OP_IMM);
				rv32ie_pkg::M_SRAI:
					word = i_word(imm[11:0] | rv32ie_pkg::SRAI_BIT, rs1, 3'd5, rd,
						rv32ie_pkg::OP_IMM);
				rv32ie_pkg::M_ORI:
					word = i_word(imm[11:0], rs1, 3'd6, rd, rv32ie_pkg::OP_IMM);
				rv32ie_pkg::M_ANDI:
					word = i_word(imm[11:0], rs1, 3'd7, rd, rv32ie_pkg::OP_IMM);
				rv32ie_pkg::M_LB:
					word = i_word(imm[11:0], rs1, 3'd0, rd, rv32ie_pkg::OP_LOAD);
				rv32ie_pkg::M_LH:
					word = i_word(imm[11:0], rs1, 3'd1, rd, rv32ie_pkg::OP_LOAD);
				rv32ie_pkg::M_LW:
					word = i_word(imm[11:0], rs1, 3'd2, rd, rv32ie_pkg::OP_LOAD);
				rv32ie_pkg::M_LBU:
					word = i_word(imm[11:0], rs1, 3'd4, rd, rv32ie_pkg::OP_LOAD);
				rv32ie_pkg::M_LHU:
					word = i_word(imm[11:0], rs1, 3'd5, rd, rv32ie_pkg::OP_LOAD);
				rv32ie_pkg::M_SB:     word = s_word(imm, 3'd0, c);
				rv32ie_pkg::M_SH:     word = s_word(imm, 3'd1, c);
				rv32ie_pkg::M_SW:     word = s_word(imm, 3'd2, c);
				rv32ie_pkg::M_BEQ:    word = b_word(imm, 3'd0, c);
				rv32ie_pkg::M_BNE:    word = b_word(imm, 3'd1, c);
				rv32ie_pkg::M_BLT:    word = b_word(imm, 3'd4, c);
				rv32ie_pkg::M_BGE:    word = b_word(imm, 3'd5, c);
				rv32ie_pkg::M_BLTU:   word = b_word(imm, 3'd6, c);
				rv32ie_pkg::M_BGEU:   word = b_word(imm, 3'd7, c);
				rv32ie_pkg::M_LUI:    word = {imm[31:12], rd, rv32ie_pkg::OP_LUI};
				rv32ie_pkg::M_AUIPC:  word = {imm[31:12], rd, rv32ie_pkg::OP_AUIPC};
				rv32ie_pkg::M_JAL:    word = j_word(imm, rd);
				rv32ie_pkg::M_JALR:
					word = i_word(imm[11:0], rs1, 3'd0, rd, rv32ie_pkg::OP_JALR);
				rv32ie_pkg::M_ECALL:  word = rv32ie_pkg::WORD_ECALL;
				rv32ie_pkg::M_EBREAK: word = rv32ie_pkg::WORD_EBREAK;
				rv32ie_pkg::M_MRET:   word = rv32ie_pkg::WORD_MRET;
				rv32ie_pkg::M_CSRRW:  word = csr_word(c, rs1, 3'd1);
				rv32ie_pkg::M_CSRRS:  word = csr_word(c, rs1, 3'd2);
				rv32ie_pkg::M_CSRRC:  word = csr_word(c, rs1, 3'd3);
				rv32ie_pkg::M_CSRRWI: word = csr_word(c, imm[4:0], 3'd5);
				rv32ie_pkg::M_CSRRSI: word = csr_word(c, imm[4:0], 3'd6);
				rv32ie_pkg::M_CSRRCI: word = csr_word(c, imm[4:0], 3'd7);
				rv32ie_pkg::M_LI: begin
					shifted = imm + 32'h0000_0800;
					if (shifted < 32'h0000_1000) begin
						word = i_word(imm[11:0], 5'd0, 3'd0, rd, rv32ie_pkg::OP_IMM);
					end else begin
						// wide li: lui with rounded upper part, then addi rd,rd,lo
						upper = {shifted[31:12], 12'h000};
						low   = imm - upper;
						push_word({upper[31:12], rd, rv32ie_pkg::OP_LUI}, 1'b0, 1'b0);
						word  = i_word(low[11:0], rd, 3'd0, rd, rv32ie_pkg::OP_IMM);
					end
				end
				rv32ie_pkg::M_NOP:    word = rv32ie_pkg::WORD_NOP;
				rv32ie_pkg::M_HALT:   word = rv32ie_pkg::WORD_HALT;
				default:              bad = 1'b1;
			endcase
			push_word(word, 1'b1, bad);
		endfunction

		// Called on each result strobe
		function void check_word(rv32ie_pkg::result_t got);
			rv32ie_pkg::result_t want;
			if (expected_words.size() == 0) begin
				$error("unexpected result: instr_word %08h last_word %0b bad_mode %0b",
					got.instr_word, got.last_word, got.bad_mode);
				errors++;
				return;
			end
			want = expected_words.pop_front();
			if (got.instr_word !== want.instr_word) begin
				$error("instr_word: expected %08h, actual %08h", want.instr_word,
					got.instr_word);
				errors++;
			end
			if (got.last_word !== want.last_word) begin
				$error("last_word: expected %0b, actual %0b", want.last_word, got.last_word);
				errors++;
			end
			if (got.bad_mode !== want.bad_mode) begin
				$error("bad_mode: expected %0b, actual %0b", want.bad_mode, got.bad_mode);
				errors++;
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function void check_drained();
			if (expected_words.size() != 0) begin
				$error("%0d expected words never arrived", expected_words.size());
				errors++;
			end
		endfunction
	endclass

	// -----------------------------------------------------------------------
	// Clock, reset and block under test
	// -----------------------------------------------------------------------
	logic                clk    = 1'b0;
	logic                arst_n = 1'b0;
	logic                start  = 1'b0;
	rv32ie_pkg::cmd_t    cmd    = '0;
	logic                busy;
	logic                result_valid;
	rv32ie_pkg::result_t result;

	word_scoreboard board = new();
	int             stall_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rv32im_instruction_encoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid),
		.result       (result)
	);

	// -----------------------------------------------------------------------
	// Monitor: everything sampled at the rising edge sees pre-edge values,
	// since all drivers and the block update through nonblocking assignments.
	// Note before check: a result can never belong to the same-edge transfer.
	// -----------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				board.note_command(cmd);
			if (result_valid)
				board.check_word(result);
		end
	end

	// Watchdog: cycles with neither a command transfer nor a result strobe
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("FAIL rv32im_instruction_encoder");
				$finish;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Stimulus helpers
	// -----------------------------------------------------------------------
	function automatic rv32ie_pkg::cmd_t make_cmd(logic [5:0] mode, logic [4:0] rd,
			logic [4:0] rs1, logic [4:0] rs2, logic [31:0] imm, logic [11:0] csr);
		rv32ie_pkg::cmd_t c;
		c.mode      = mode;
		c.dest_reg  = rd;
		c.src1_reg  = rs1;
		c.src2_reg  = rs2;
		c.imm_value = imm;
		c.csr_addr  = csr;
		return c;
	endfunction

	// Mostly valid mnemonics, li weighted up so both li paths get plenty of
	// traffic, a few unused codes. Immediates lean on the li split edges.
	function automatic rv32ie_pkg::cmd_t random_command();
		rv32ie_pkg::cmd_t c;
		int               pick;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			c.mode = 6'($urandom_range(57, 63));
		else if (pick < 22)
			c.mode = rv32ie_pkg::M_LI;
		else
			c.mode = 6'($urandom_range(0, 56));
		c.dest_reg = 5'($urandom);
		c.src1_reg = 5'($urandom);
		c.src2_reg = 5'($urandom);
		c.csr_addr = 12'($urandom);
		case ($urandom_range(0, 4))
			0: c.imm_value = $urandom;
			1: c.imm_value = $urandom_range(0, 4095) - 2048;
			// straddle the 12-bit signed limits
			2: c.imm_value = ($urandom_range(0, 1) ? 32'd2040 : -32'd2056)
					+ $urandom_range(0, 15);
			// near the top of the positive and the unsigned range, where the upper part wraps
			3: c.imm_value = ($urandom_range(0, 1) ? 32'h7FFF_F000 : 32'hFFFF_F000)
					+ $urandom_range(0, 4095);
			default: begin
				c.imm_value = 32'h1 << $urandom_range(0, 31);
				if ($urandom_range(0, 1))
					c.imm_value = ~c.imm_value;
			end
		endcase
		return c;
	endfunction

	// One command transfer. An optional idle gap goes first, with start low
	// and junk on cmd; then start stays high until busy is low at an edge.
	task automatic drive_command(input rv32ie_pkg::cmd_t c, input bit may_idle);
		int gap;
		if (may_idle && $urandom_range(0, 99) < 13) begin
			gap   = $urandom_range(1, 4);
			start <= 1'b0;
			cmd   <= random_command();
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// -----------------------------------------------------------------------
	// Test sequence
	// -----------------------------------------------------------------------
	initial begin
		rv32ie_pkg::cmd_t specials[$];
		rv32ie_pkg::cmd_t c;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every mnemonic code once, unused ones included
		for (int code = 0; code < 64; code++) begin
			c      = random_command();
			c.mode = 6'(code);
			drive_command(c, 1'b1);
		end

		// corner cases: shift masking, upper immediates, li split edges,
		// offset truncation, csr immediate field, register extremes
		specials = {
			make_cmd(rv32ie_pkg::M_SLLI,   5'd31, 5'd31, 5'd0,  32'hFFFF_FFFF, 12'h000),
			make_cmd(rv32ie_pkg::M_SRAI,   5'd0,  5'd0,  5'd31, 32'h0000_0000, 12'hFFF),
			make_cmd(rv32ie_pkg::M_SRAI,   5'd31, 5'd1,  5'd0,  32'hFFFF_FFFF, 12'h000),
			make_cmd(rv32ie_pkg::M_SRLI,   5'd1,  5'd31, 5'd0,  32'hFFFF_FFFF, 12'h000),
			make_cmd(rv32ie_pkg::M_LUI,    5'd31, 5'd0,  5'd0,  32'hFFFF_FFFF, 12'h000),
			make_cmd(rv32ie_pkg::M_LUI,    5'd0,  5'd0,  5'd0,  32'h0000_0FFF, 12'h000),
			make_cmd(rv32ie_pkg::M_AUIPC,  5'd5,  5'd0,  5'd0,  32'h8000_0000, 12'h000),
			make_cmd(rv32ie_pkg::M_LI,     5'd10, 5'd7,  5'd9,  32'd2047,      12'h000),
			make_cmd(rv32ie_pkg::M_LI,     5'd11, 5'd0,  5'd0,  -32'd2048,     12'h000),
			make_cmd(rv32ie_pkg::M_LI,     5'd12, 5'd0,  5'd0,  32'd2048,      12'h000),
			make_cmd(rv32ie_pkg::M_LI,     5'd13, 5'd0,  5'd0,  -32'd2049,     12'h000),
			make_cmd(rv32ie_pkg::M_LI,     5'd31, 5'd0,  5'd0,  32'h7FFF_FFFF, 12'h000),
			make_cmd(rv32ie_pkg::M_LI,     5'd0,  5'd0,  5'd0,  32'h8000_0000, 12'h000),
			make_cmd(rv32ie_pkg::M_LI,     5'd14, 5'd0,  5'd0,  32'h7FFF_F800, 12'h000),
			make_cmd(rv32ie_pkg::M_LI,     5'd15, 5'd0,  5'd0,  32'hFFFF_FFFF, 12'h000),
			make_cmd(rv32ie_pkg::M_LI,     5'd16, 5'd0,  5'd0,  32'h0000_0000, 12'h000),
			make_cmd(rv32ie_pkg::M_BEQ,    5'd0,  5'd31, 5'd31, 32'h0000_1FFF, 12'h000),
			make_cmd(rv32ie_pkg::M_BGEU,   5'd0,  5'd0,  5'd0,  32'hFFFF_F001, 12'h000),
			make_cmd(rv32ie_pkg::M_JAL,    5'd31, 5'd0,  5'd0,  32'h001F_FFFF, 12'h000),
			make_cmd(rv32ie_pkg::M_JAL,    5'd1,  5'd0,  5'd0,  32'hFFE0_0001, 12'h000),
			make_cmd(rv32ie_pkg::M_CSRRWI, 5'd31, 5'd0,  5'd0,  32'hFFFF_FFFF, 12'hFFF),
			make_cmd(rv32ie_pkg::M_CSRRCI, 5'd0,  5'd31, 5'd0,  32'h0000_0000, 12'h000),
			make_cmd(rv32ie_pkg::M_SW,     5'd0,  5'd31, 5'd31, 32'hFFFF_FFFF, 12'h000),
			make_cmd(6'd63,                5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, 12'hFFF)
		};
		foreach (specials[i])
			drive_command(specials[i], 1'b1);

		// random traffic; a middle window runs back to back with no gaps
		for (int i = 0; i < RANDOM_ITEMS; i++)
			drive_command(random_command(), !(i >= QUIET_FIRST && i < QUIET_LAST));
		start <= 1'b0;

		// drain, then give stray words time to show up
		while (board.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		board.check_drained();

		if (board.errors == 0)
			$display("PASS rv32im_instruction_encoder");
		else
			$display("FAIL rv32im_instruction_encoder");
		$finish;
	end

endmodule
